// ===== src/bse_pkg.sv =====
// Shared types, widths, segment codes and arithmetic helpers for the
// Bezier segment evaluator. No dependencies.
package bse_pkg;

  localparam int CW = 16;              // coordinate width
  localparam int TF = 16;              // fraction bits of t
  localparam int TW = TF + 1;          // t width, Q1.TF
  localparam int AW = CW + TF;         // first de Casteljau level, Q(TF)
  localparam int BW = CW + 2 * TF;     // second level, Q(2TF)
  localparam int RW = CW + 3 * TF;     // third level, Q(3TF)

  localparam logic [1:0] MODE_LINE  = 2'd0;
  localparam logic [1:0] MODE_QUAD  = 2'd1;
  localparam logic [1:0] MODE_CUBIC = 2'd2;
  localparam logic [1:0] MODE_CLOSE = 2'd3;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [TW-1:0]        tq_t;
  typedef logic signed [AW-1:0] acc_a_t;
  typedef logic signed [BW-1:0] acc_b_t;
  typedef logic signed [RW-1:0] acc_r_t;

  localparam tq_t T_ONE = {1'b1, {TF{1'b0}}};

  typedef struct packed {
    logic       vld;
    logic [1:0] mode;
    tq_t        t;
    tq_t        s;
    coord_t     cx0, cx1, cx2, cx3;
    coord_t     cy0, cy1, cy2, cy3;
  } prep_t;

  typedef struct packed {
    logic       vld;
    logic [1:0] mode;
    tq_t        t;
    tq_t        s;
    acc_a_t     ax0, ax1, ax2;
    acc_a_t     ay0, ay1, ay2;
  } lvl1_t;

  typedef struct packed {
    logic       vld;
    logic [1:0] mode;
    tq_t        t;
    tq_t        s;
    acc_b_t     bx0, bx1;
    acc_b_t     by0, by1;
  } lvl2_t;

  typedef struct packed {
    logic   vld;
    acc_r_t rx;
    acc_r_t ry;
  } lvl3_t;

  // c0*s + c1*t at each level; exact, the sum always fits the result width
  function automatic acc_a_t lerp_a(coord_t c0, coord_t c1, tq_t s, tq_t t);
    logic signed [AW+1:0] p;
    p = c0 * $signed({1'b0, s}) + c1 * $signed({1'b0, t});
    return p[AW-1:0];
  endfunction

  function automatic acc_b_t lerp_b(acc_a_t c0, acc_a_t c1, tq_t s, tq_t t);
    logic signed [BW+1:0] p;
    p = c0 * $signed({1'b0, s}) + c1 * $signed({1'b0, t});
    return p[BW-1:0];
  endfunction

  function automatic acc_r_t lerp_c(acc_b_t c0, acc_b_t c1, tq_t s, tq_t t);
    logic signed [RW+1:0] p;
    p = c0 * $signed({1'b0, s}) + c1 * $signed({1'b0, t});
    return p[RW-1:0];
  endfunction

  // round to nearest, halves upward, from Q(3TF)
  function automatic coord_t round_out(acc_r_t r);
    logic [RW-1:0] q;
    q = r + (RW'(1) << (3 * TF - 1));
    return q[3*TF +: CW];
  endfunction

endpackage

// ===== src/bse_if.sv =====
// Stream interfaces of the Bezier segment evaluator: segment in, point out.
// Depends on bse_pkg.
interface bse_in_if;
  logic            valid;
  logic            ready;
  logic [1:0]      mode;
  bse_pkg::tq_t    t;
  bse_pkg::coord_t p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y;

  modport source (output valid, mode, t, p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y,
                  input ready);
  modport sink   (input valid, mode, t, p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y,
                  output ready);
endinterface

interface bse_out_if;
  logic            valid;
  logic            ready;
  bse_pkg::coord_t pos_x, pos_y;

  modport source (output valid, pos_x, pos_y, input ready);
  modport sink   (input valid, pos_x, pos_y, output ready);
endinterface

// ===== src/bse_prep.sv =====
// Entry stage: clamps t to 1.0, forms s = 1 - t, registers the segment.
// Depends on bse_pkg and bse_in_if.
module bse_prep (
  input  logic           clk,
  input  logic           rst_n,
  bse_in_if.sink         in_ch,
  output bse_pkg::prep_t d_o,
  input  logic           ready_i
);

  bse_pkg::prep_t stage_r, stage_nxt;
  bse_pkg::tq_t   t_c;
  logic           ready_o;

  assign ready_o     = !stage_r.vld || ready_i;
  assign in_ch.ready = ready_o;
  assign d_o         = stage_r;

  always_comb begin
    t_c = (in_ch.t > bse_pkg::T_ONE) ? bse_pkg::T_ONE : in_ch.t;
    stage_nxt.vld  = 1'b1;
    stage_nxt.mode = in_ch.mode;
    stage_nxt.t    = t_c;
    stage_nxt.s    = bse_pkg::T_ONE - t_c;
    stage_nxt.cx0  = in_ch.p0x;
    stage_nxt.cx1  = in_ch.p1x;
    stage_nxt.cx2  = in_ch.p2x;
    stage_nxt.cx3  = in_ch.p3x;
    stage_nxt.cy0  = in_ch.p0y;
    stage_nxt.cy1  = in_ch.p1y;
    stage_nxt.cy2  = in_ch.p2y;
    stage_nxt.cy3  = in_ch.p3y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.vld <= 1'b0;
    end else if (ready_o) begin
      if (in_ch.valid) begin
        stage_r <= stage_nxt;
      end else begin
        stage_r.vld <= 1'b0;
      end
    end
  end

endmodule

// ===== src/bse_lvl1.sv =====
// First de Casteljau level: three lerps per axis between adjacent points.
// Depends on bse_pkg.
module bse_lvl1 (
  input  logic           clk,
  input  logic           rst_n,
  input  bse_pkg::prep_t d_i,
  output logic           ready_o,
  output bse_pkg::lvl1_t d_o,
  input  logic           ready_i
);

  bse_pkg::lvl1_t stage_r, stage_nxt;

  assign ready_o = !stage_r.vld || ready_i;
  assign d_o     = stage_r;

  always_comb begin
    stage_nxt.vld  = 1'b1;
    stage_nxt.mode = d_i.mode;
    stage_nxt.t    = d_i.t;
    stage_nxt.s    = d_i.s;
    stage_nxt.ax0  = bse_pkg::lerp_a(d_i.cx0, d_i.cx1, d_i.s, d_i.t);
    stage_nxt.ax1  = bse_pkg::lerp_a(d_i.cx1, d_i.cx2, d_i.s, d_i.t);
    stage_nxt.ax2  = bse_pkg::lerp_a(d_i.cx2, d_i.cx3, d_i.s, d_i.t);
    stage_nxt.ay0  = bse_pkg::lerp_a(d_i.cy0, d_i.cy1, d_i.s, d_i.t);
    stage_nxt.ay1  = bse_pkg::lerp_a(d_i.cy1, d_i.cy2, d_i.s, d_i.t);
    stage_nxt.ay2  = bse_pkg::lerp_a(d_i.cy2, d_i.cy3, d_i.s, d_i.t);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.vld <= 1'b0;
    end else if (ready_o) begin
      if (d_i.vld) begin
        stage_r <= stage_nxt;
      end else begin
        stage_r.vld <= 1'b0;
      end
    end
  end

endmodule

// ===== src/bse_lvl2.sv =====
// Second de Casteljau level. A line repeats its single first-level point,
// which scales it by s + t = 1.0 and keeps the sum exact.
// Depends on bse_pkg.
module bse_lvl2 (
  input  logic           clk,
  input  logic           rst_n,
  input  bse_pkg::lvl1_t d_i,
  output logic           ready_o,
  output bse_pkg::lvl2_t d_o,
  input  logic           ready_i
);

  bse_pkg::lvl2_t  stage_r, stage_nxt;
  bse_pkg::acc_a_t ax1_sel, ay1_sel;
  logic            is_line;

  assign ready_o = !stage_r.vld || ready_i;
  assign d_o     = stage_r;

  always_comb begin
    is_line = (d_i.mode == bse_pkg::MODE_LINE) || (d_i.mode == bse_pkg::MODE_CLOSE);
    ax1_sel = is_line ? d_i.ax0 : d_i.ax1;
    ay1_sel = is_line ? d_i.ay0 : d_i.ay1;
    stage_nxt.vld  = 1'b1;
    stage_nxt.mode = d_i.mode;
    stage_nxt.t    = d_i.t;
    stage_nxt.s    = d_i.s;
    stage_nxt.bx0  = bse_pkg::lerp_b(d_i.ax0, ax1_sel, d_i.s, d_i.t);
    stage_nxt.bx1  = bse_pkg::lerp_b(d_i.ax1, d_i.ax2, d_i.s, d_i.t);
    stage_nxt.by0  = bse_pkg::lerp_b(d_i.ay0, ay1_sel, d_i.s, d_i.t);
    stage_nxt.by1  = bse_pkg::lerp_b(d_i.ay1, d_i.ay2, d_i.s, d_i.t);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.vld <= 1'b0;
    end else if (ready_o) begin
      if (d_i.vld) begin
        stage_r <= stage_nxt;
      end else begin
        stage_r.vld <= 1'b0;
      end
    end
  end

endmodule

// ===== src/bse_lvl3.sv =====
// Third de Casteljau level; anything below cubic repeats its point so the
// result is always in Q(3TF). Depends on bse_pkg.
module bse_lvl3 (
  input  logic           clk,
  input  logic           rst_n,
  input  bse_pkg::lvl2_t d_i,
  output logic           ready_o,
  output bse_pkg::lvl3_t d_o,
  input  logic           ready_i
);

  bse_pkg::lvl3_t  stage_r, stage_nxt;
  bse_pkg::acc_b_t bx1_sel, by1_sel;
  logic            is_cubic;

  assign ready_o = !stage_r.vld || ready_i;
  assign d_o     = stage_r;

  always_comb begin
    is_cubic = (d_i.mode == bse_pkg::MODE_CUBIC);
    bx1_sel  = is_cubic ? d_i.bx1 : d_i.bx0;
    by1_sel  = is_cubic ? d_i.by1 : d_i.by0;
    stage_nxt.vld = 1'b1;
    stage_nxt.rx  = bse_pkg::lerp_c(d_i.bx0, bx1_sel, d_i.s, d_i.t);
    stage_nxt.ry  = bse_pkg::lerp_c(d_i.by0, by1_sel, d_i.s, d_i.t);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.vld <= 1'b0;
    end else if (ready_o) begin
      if (d_i.vld) begin
        stage_r <= stage_nxt;
      end else begin
        stage_r.vld <= 1'b0;
      end
    end
  end

endmodule

// ===== src/bezier_segment_evaluate.sv =====
// Bezier segment evaluator: takes one path segment (line, quadratic, cubic or
// closing line) and a parameter t in unsigned Q1.16, clamped to 1.0, and
// returns the point on it, rounded to nearest with halves going up. The
// point is built by de Casteljau's construction in exact integers, one
// level per pipeline stage, so the result equals the Bernstein-weighted
// sum bit for bit. A closing line is a line from p0 to the path start that
// arrives in p1. Throughput is one segment per clock while the output is
// not stalled, and each segment passes through five register stages:
// clamp, three lerp levels and the rounding stage. Each stage has its own
// valid bit and accepts when it is empty or draining, so bubbles close up
// and in_ch.ready only drops when every stage holds an item and the output
// is stalled. The critical path is the third-level 48 x 17 bit multiply-add.
// Depends on bse_pkg, bse_if and the stage modules.
module bezier_segment_evaluate (
  input  logic     clk,
  input  logic     rst_n,
  bse_in_if.sink   in_ch,
  bse_out_if.source out_ch
);

  bse_pkg::prep_t d0;
  bse_pkg::lvl1_t d1;
  bse_pkg::lvl2_t d2;
  bse_pkg::lvl3_t d3;
  logic           rdy1, rdy2, rdy3, rdy4;

  // output stage registers
  logic            out_valid_r;
  bse_pkg::coord_t pos_x_r, pos_y_r;

  bse_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .d_o     (d0),
    .ready_i (rdy1)
  );

  bse_lvl1 u_lvl1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .d_i     (d0),
    .ready_o (rdy1),
    .d_o     (d1),
    .ready_i (rdy2)
  );

  bse_lvl2 u_lvl2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .d_i     (d1),
    .ready_o (rdy2),
    .d_o     (d2),
    .ready_i (rdy3)
  );

  bse_lvl3 u_lvl3 (
    .clk     (clk),
    .rst_n   (rst_n),
    .d_i     (d2),
    .ready_o (rdy3),
    .d_o     (d3),
    .ready_i (rdy4)
  );

  // rounding stage doubles as the output register
  assign rdy4 = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy4) begin
      out_valid_r <= d3.vld;
      if (d3.vld) begin
        pos_x_r <= bse_pkg::round_out(d3.rx);
        pos_y_r <= bse_pkg::round_out(d3.ry);
      end
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.pos_x = pos_x_r;
  assign out_ch.pos_y = pos_y_r;

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");

  // an empty output stage means every stage upstream can take a transfer
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input blocked with output stage empty");

  // a finished item reaches an empty output stage in the next cycle
  a_last_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (d3.vld && !out_ch.valid) |=> out_ch.valid)
    else $error("item lost between level three and output");

  // output only becomes valid from a finished item
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(d3.vld))
    else $error("output valid without an item");

endmodule

// ===== tb/bse_point_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the Bezier segment evaluator: predicts one point per
// accepted segment and checks returned points in order. Needs bse_pkg, bse_if.
module bse_point_checker (
  input  logic clk,
  input  logic rst_n,
  bse_in_if    seg_mon,
  bse_out_if   pt_mon,
  output int   mismatches,
  output int   outstanding
);

  typedef logic signed [79:0] wide_t;
  typedef struct packed {
    bse_pkg::coord_t x;
    bse_pkg::coord_t y;
  } point_t;

  point_t expected_points[$];
  int     err_cnt = 0;

  // Bernstein sum of one axis in exact integers, rounded half up.
  function automatic bse_pkg::coord_t bernstein_axis(logic [1:0] mode,
                                                     bse_pkg::tq_t t_in,
                                                     bse_pkg::coord_t c0,
                                                     bse_pkg::coord_t c1,
                                                     bse_pkg::coord_t c2,
                                                     bse_pkg::coord_t c3);
    wide_t t, s, a0, a1, a2, a3, acc, rnd;
    int    sh;
    t  = (t_in > bse_pkg::T_ONE) ? bse_pkg::T_ONE : t_in;
    s  = wide_t'(bse_pkg::T_ONE) - t;
    a0 = c0;
    a1 = c1;
    a2 = c2;
    a3 = c3;
    case (mode)
      bse_pkg::MODE_QUAD: begin
        acc = a0 * s * s + a1 * 2 * s * t + a2 * t * t;
        sh  = 2 * bse_pkg::TF;
      end
      bse_pkg::MODE_CUBIC: begin
        acc = a0 * s * s * s + a1 * 3 * s * s * t + a2 * 3 * s * t * t + a3 * t * t * t;
        sh  = 3 * bse_pkg::TF;
      end
      default: begin
        // line and closing line
        acc = a0 * s + a1 * t;
        sh  = bse_pkg::TF;
      end
    endcase
    rnd = (acc + (wide_t'(1) <<< (sh - 1))) >>> sh;
    return rnd[bse_pkg::CW-1:0];
  endfunction

  always @(posedge clk) begin
    point_t want, got;
    if (rst_n) begin
      if (seg_mon.valid && seg_mon.ready) begin
        want.x = bernstein_axis(seg_mon.mode, seg_mon.t, seg_mon.p0x, seg_mon.p1x,
                                seg_mon.p2x, seg_mon.p3x);
        want.y = bernstein_axis(seg_mon.mode, seg_mon.t, seg_mon.p0y, seg_mon.p1y,
                                seg_mon.p2y, seg_mon.p3y);
        expected_points = {expected_points, want};
      end
      if (pt_mon.valid && pt_mon.ready) begin
        got.x = pt_mon.pos_x;
        got.y = pt_mon.pos_y;
        if (expected_points.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected point transfer: x=%0d y=%0d", got.x, got.y);
        end else begin
          want = expected_points.pop_front();
          if (got.x != want.x || got.y != want.y) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("point mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                       want.x, want.y, got.x, got.y);
          end
        end
      end
    end
    mismatches  <= err_cnt;
    outstanding <= expected_points.size();
  end

endmodule

// ===== tb/bezier_segment_evaluate_tb.sv =====
`timescale 1ns / 100ps
// Top of the Bezier segment evaluator testbench: clock, reset, segment
// stimulus, point receiver, watchdog and verdict. Needs bse_pkg, bse_if,
// the block and bse_point_checker.
module bezier_segment_evaluate_tb;

  localparam int              LONG_HOLD      = 300;   // receiver hold-off, cycles
  localparam int              IDLE_LIMIT     = 4000;  // cycles with no transfer before giving up
  localparam int              TAIL_CYCLES    = 20;    // cycles waited before the verdict
  localparam int              RAND_PER_PHASE = 210;
  localparam bse_pkg::coord_t C_MIN          = 16'h8000;
  localparam bse_pkg::coord_t C_MAX          = 16'h7FFF;

  typedef struct packed {
    logic [1:0]      mode;
    bse_pkg::tq_t    t;
    bse_pkg::coord_t p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y;
  } segment_t;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   outstanding;
  int   gap_pct;     // chance in 100 that the sender idles a cycle
  int   stall_pct;   // chance in 100 that the receiver stalls a cycle
  logic hold_tgl;    // toggled by the stimulus to request one long hold-off
  logic hold_ack;    // receiver's copy of the last request served

  bse_in_if  seg_ch ();
  bse_out_if pt_ch ();

  bezier_segment_evaluate dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (seg_ch),
    .out_ch (pt_ch)
  );

  bse_point_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .seg_mon     (seg_ch),
    .pt_mon      (pt_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, or one long hold-off per request. During the
  // hold-off ready stays low, the pipeline fills and in_ch.ready drops.
  initial begin
    hold_ack    = 1'b0;
    pt_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_tgl != hold_ack) begin
        hold_ack = hold_tgl;
        pt_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        pt_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Watchdog: ends the run if no transfer happens on either channel for
  // too long, which also catches points that never come.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((seg_ch.valid && seg_ch.ready) || (pt_ch.valid && pt_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("bezier_segment_evaluate_tb failed");
    $finish;
  end

  // Coordinates lean on the extremes and on small values near zero.
  function automatic bse_pkg::coord_t pick_coord();
    case ($urandom_range(9))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return bse_pkg::coord_t'($urandom_range(8) - 4);
      default: return bse_pkg::coord_t'($urandom);
    endcase
  endfunction

  // Mostly t in [0, 1.0], some exact ends, some above one to hit the clamp.
  function automatic bse_pkg::tq_t pick_t();
    case ($urandom_range(19))
      0:       return '0;
      1:       return bse_pkg::T_ONE;
      2, 3:    return bse_pkg::tq_t'($urandom_range(131071, 65537));
      default: return bse_pkg::tq_t'($urandom_range(65536));
    endcase
  endfunction

  function automatic segment_t random_segment();
    segment_t seg;
    seg.mode = 2'($urandom_range(3));
    seg.t    = pick_t();
    seg.p0x  = pick_coord();
    seg.p0y  = pick_coord();
    seg.p1x  = pick_coord();
    seg.p1y  = pick_coord();
    seg.p2x  = pick_coord();
    seg.p2y  = pick_coord();
    seg.p3x  = pick_coord();
    seg.p3y  = pick_coord();
    return seg;
  endfunction

  // One segment transfer, after a random number of idle cycles. Valid is
  // left high on return so back-to-back segments need no extra edge.
  task automatic put_segment(segment_t seg);
    while ($urandom_range(99) < gap_pct) begin
      seg_ch.valid <= 1'b0;
      @(posedge clk);
    end
    seg_ch.valid <= 1'b1;
    seg_ch.mode  <= seg.mode;
    seg_ch.t     <= seg.t;
    seg_ch.p0x   <= seg.p0x;
    seg_ch.p0y   <= seg.p0y;
    seg_ch.p1x   <= seg.p1x;
    seg_ch.p1y   <= seg.p1y;
    seg_ch.p2x   <= seg.p2x;
    seg_ch.p2y   <= seg.p2y;
    seg_ch.p3x   <= seg.p3x;
    seg_ch.p3y   <= seg.p3y;
    @(posedge clk);
    while (!seg_ch.ready) @(posedge clk);
  endtask

  // Sender goes quiet until every predicted point has been returned.
  task automatic drain_points();
    seg_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    rst_n        = 1'b0;
    gap_pct      = 0;
    stall_pct    = 0;
    hold_tgl     = 1'b0;
    seg_ch.valid = 1'b0;
    seg_ch.mode  = bse_pkg::MODE_LINE;
    seg_ch.t     = '0;
    seg_ch.p0x   = '0;
    seg_ch.p0y   = '0;
    seg_ch.p1x   = '0;
    seg_ch.p1y   = '0;
    seg_ch.p2x   = '0;
    seg_ch.p2y   = '0;
    seg_ch.p3x   = '0;
    seg_ch.p3y   = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: ends of t, clamp above one, halves rounding both ways,
    // closing line against plain line, unused points carrying garbage.
    put_segment(segment_t'{bse_pkg::MODE_LINE, 17'd0, C_MIN, C_MAX, C_MAX, C_MIN,
                           16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0});
    put_segment(segment_t'{bse_pkg::MODE_LINE, bse_pkg::T_ONE, C_MIN, C_MAX, C_MAX, C_MIN,
                           C_MAX, C_MAX, C_MIN, C_MIN});
    put_segment(segment_t'{bse_pkg::MODE_LINE, 17'd131071, C_MIN, C_MAX, C_MAX, C_MIN,
                           16'h0F0F, 16'hF0F0, 16'hAAAA, 16'h5555});
    put_segment(segment_t'{bse_pkg::MODE_LINE, 17'd65537, 16'd100, -16'sd100, -16'sd7,
                           16'd9, '0, '0, '0, '0});
    // tie at one half: x rounds 0.5 up to 1, y rounds -0.5 up to 0
    put_segment(segment_t'{bse_pkg::MODE_CLOSE, 17'd32768, 16'd0, 16'd0, 16'd1, -16'sd1,
                           C_MAX, C_MIN, C_MAX, C_MIN});
    put_segment(segment_t'{bse_pkg::MODE_LINE, 17'd32768, 16'd0, 16'd0, 16'd1, -16'sd1,
                           '0, '0, '0, '0});
    put_segment(segment_t'{bse_pkg::MODE_CLOSE, 17'd16384, C_MAX, C_MIN, C_MIN, C_MAX,
                           16'h1111, 16'h2222, 16'h3333, 16'h4444});
    put_segment(segment_t'{bse_pkg::MODE_LINE, 17'd32768, 16'd0, 16'd0, -16'sd1, 16'd3,
                           '0, '0, '0, '0});
    put_segment(segment_t'{bse_pkg::MODE_QUAD, 17'd0, C_MIN, C_MAX, C_MAX, C_MIN,
                           C_MAX, C_MIN, 16'h7777, 16'h8888});
    put_segment(segment_t'{bse_pkg::MODE_QUAD, bse_pkg::T_ONE, C_MIN, C_MAX, C_MAX, C_MIN,
                           C_MAX, C_MIN, 16'h7777, 16'h8888});
    put_segment(segment_t'{bse_pkg::MODE_QUAD, 17'd32768, C_MIN, C_MAX, C_MAX, C_MIN,
                           C_MIN, C_MAX, C_MAX, C_MAX});
    put_segment(segment_t'{bse_pkg::MODE_QUAD, 17'd100000, 16'd5, -16'sd5, 16'd17, 16'd23,
                           -16'sd31, C_MAX, C_MIN, C_MIN});
    put_segment(segment_t'{bse_pkg::MODE_QUAD, 17'd1, C_MAX, C_MIN, C_MIN, C_MAX,
                           C_MAX, C_MIN, '0, '0});
    put_segment(segment_t'{bse_pkg::MODE_CUBIC, 17'd0, C_MIN, C_MAX, C_MAX, C_MIN,
                           C_MIN, C_MAX, C_MAX, C_MIN});
    put_segment(segment_t'{bse_pkg::MODE_CUBIC, bse_pkg::T_ONE, C_MIN, C_MAX, C_MAX, C_MIN,
                           C_MIN, C_MAX, C_MAX, C_MIN});
    put_segment(segment_t'{bse_pkg::MODE_CUBIC, 17'd32768, C_MAX, C_MAX, C_MAX, C_MAX,
                           C_MAX, C_MAX, C_MAX, C_MAX});
    put_segment(segment_t'{bse_pkg::MODE_CUBIC, 17'd32768, C_MIN, C_MIN, C_MIN, C_MIN,
                           C_MIN, C_MIN, C_MIN, C_MIN});
    put_segment(segment_t'{bse_pkg::MODE_CUBIC, 17'd1, C_MIN, C_MAX, C_MAX, C_MIN,
                           C_MAX, C_MIN, C_MIN, C_MAX});
    put_segment(segment_t'{bse_pkg::MODE_CUBIC, 17'd65535, C_MAX, C_MIN, C_MIN, C_MAX,
                           C_MAX, C_MIN, C_MIN, C_MAX});
    put_segment(segment_t'{bse_pkg::MODE_CUBIC, 17'd77881, 16'd1, -16'sd2, 16'd3, -16'sd4,
                           16'd5, -16'sd6, 16'd7, -16'sd8});
    drain_points();

    // Random phases: free flow, sender gaps, receiver stalls, both.
    // The first phase also gets the long receiver hold-off, with the
    // sender still pushing so the pipeline backs up into in_ch.ready.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 55; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 55; end
        default: begin gap_pct = 37; stall_pct = 37; end
      endcase
      if (ph == 0)
        hold_tgl <= ~hold_tgl;
      repeat (RAND_PER_PHASE) put_segment(random_segment());
      drain_points();
    end

    stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("bezier_segment_evaluate_tb passed");
    else
      $display("bezier_segment_evaluate_tb failed");
    $finish;
  end

endmodule

// ===== files.f =====
src/bse_pkg.sv
src/bse_if.sv
src/bse_prep.sv
src/bse_lvl1.sv
src/bse_lvl2.sv
src/bse_lvl3.sv
src/bezier_segment_evaluate.sv
tb/bse_point_checker.sv
tb/bezier_segment_evaluate_tb.sv
